[rtl/core/snlf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snlf_pkg
// Shared types and constants for the serpentine LED frame loader.
// ----------------------------------------------------------------------------
package snlf_pkg;

  localparam int unsigned ColorW    = 8;
  localparam int unsigned StripIdxW = 6;

  // Component expected next in the R,G,B byte stream.
  typedef enum logic [1:0] {
    PhRed   = 2'd0,
    PhGreen = 2'd1,
    PhBlue  = 2'd2
  } phase_e;

endpackage

[rtl/core/serpentine_led_frame_loader_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serpentine_led_frame_loader_unit
// Packs a byte stream into RGB pixels and writes them to a serpentine strip.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one payload byte per request (data_byte_i) plus
//   end_of_frame_i on the final byte. Every third byte completes a pixel,
//   which comes out as one LED write on the output channel (strip_index_o,
//   red_o, green_o, blue_o, run_done_o). Bytes past COLUMNS*ROWS pixels
//   are dropped.
//   A completed pixel goes straight into the output register. Throughput is
//   one byte per cycle for normal bytes, output stalls aside. A final byte
//   that leaves N pixels unwritten starts a black fill of N writes, one per
//   cycle, output stalls aside; the input stalls until the fill ends, then
//   the counters restart. run_done_o marks the last write caused by one
//   input byte. A stall on the output holds the output register; the input
//   stalls during a fill and when that register is full and not being taken.
//   Reset clears the counters, the pixel phase and the output valid.
// ----------------------------------------------------------------------------
module serpentine_led_frame_loader_unit
  import snlf_pkg::*;
#(
  parameter int unsigned COLUMNS = 8,
  parameter int unsigned ROWS    = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ColorW-1:0]    data_byte_i,
  input  logic                 end_of_frame_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [StripIdxW-1:0] strip_index_o,
  output logic [ColorW-1:0]    red_o,
  output logic [ColorW-1:0]    green_o,
  output logic [ColorW-1:0]    blue_o,
  output logic                 run_done_o
);

  localparam int unsigned CntW = $clog2(COLUMNS * ROWS + 1);
  localparam int unsigned ColW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned RowW = $clog2(ROWS + 1);
  localparam logic [CntW-1:0] Cap     = CntW'(COLUMNS * ROWS);
  localparam logic [CntW-1:0] CapLast = CntW'(COLUMNS * ROWS - 1);
  localparam logic [ColW-1:0] ColLast = ColW'(COLUMNS - 1);

  phase_e              byte_phase_q, byte_phase_d;
  logic [ColorW-1:0]   red_hold_q, red_hold_d;
  logic [ColorW-1:0]   green_hold_q, green_hold_d;
  logic [CntW-1:0]     pixel_count_q, pixel_count_d;
  logic [ColW-1:0]     col_q, col_d;
  logic [RowW-1:0]     row_q, row_d;
  logic                fill_q, fill_d;

  logic                 out_valid_q, out_valid_d;
  logic [StripIdxW-1:0] strip_q, strip_d;
  logic [ColorW-1:0]    red_q, red_d;
  logic [ColorW-1:0]    green_q, green_d;
  logic [ColorW-1:0]    blue_q, blue_d;
  logic                 run_done_q, run_done_d;

  logic                 load_ok;
  logic                 accept;
  logic [CntW-1:0]      pc_inc;
  logic [ColW-1:0]      col_inc;
  logic [RowW-1:0]      row_inc;
  logic [RowW-1:0]      strip_row;
  logic [StripIdxW-1:0] row_base;
  logic [StripIdxW-1:0] strip_pos;

  assign load_ok    = !out_valid_q || !out_stall_i;
  assign in_stall_o = fill_q || !load_ok;
  assign accept     = in_valid_i && !in_stall_o;

  // raster position advance, kept as col/row so no divide is needed
  always_comb begin
    pc_inc = pixel_count_q + CntW'(1);
    if (col_q == ColLast) begin
      col_inc = '0;
      row_inc = row_q + RowW'(1);
    end else begin
      col_inc = col_q + ColW'(1);
      row_inc = row_q;
    end
  end

  // strip rows count from the bottom; odd strip rows run right to left
  always_comb begin
    strip_row = RowW'(ROWS - 1) - row_q;
    row_base  = StripIdxW'(strip_row) * StripIdxW'(COLUMNS);
    if (strip_row[0]) begin
      strip_pos = row_base + StripIdxW'(COLUMNS - 1) - StripIdxW'(col_q);
    end else begin
      strip_pos = row_base + StripIdxW'(col_q);
    end
  end

  always_comb begin
    byte_phase_d  = byte_phase_q;
    red_hold_d    = red_hold_q;
    green_hold_d  = green_hold_q;
    pixel_count_d = pixel_count_q;
    col_d         = col_q;
    row_d         = row_q;
    fill_d        = fill_q;
    out_valid_d   = out_valid_q;
    strip_d       = strip_q;
    red_d         = red_q;
    green_d       = green_q;
    blue_d        = blue_q;
    run_done_d    = run_done_q;

    if (load_ok) begin
      out_valid_d = 1'b0;
    end

    if (fill_q) begin
      if (load_ok) begin
        out_valid_d = 1'b1;
        strip_d     = strip_pos;
        red_d       = '0;
        green_d     = '0;
        blue_d      = '0;
        run_done_d  = (pixel_count_q == CapLast);
        if (pixel_count_q == CapLast) begin
          fill_d        = 1'b0;
          pixel_count_d = '0;
          col_d         = '0;
          row_d         = '0;
        end else begin
          pixel_count_d = pc_inc;
          col_d         = col_inc;
          row_d         = row_inc;
        end
      end
    end else if (accept) begin
      if (pixel_count_q < Cap) begin
        unique case (byte_phase_q)
          PhRed: begin
            red_hold_d   = data_byte_i;
            byte_phase_d = PhGreen;
          end
          PhGreen: begin
            green_hold_d = data_byte_i;
            byte_phase_d = PhBlue;
          end
          PhBlue: begin
            byte_phase_d  = PhRed;
            pixel_count_d = pc_inc;
            col_d         = col_inc;
            row_d         = row_inc;
            out_valid_d   = 1'b1;
            strip_d       = strip_pos;
            red_d         = red_hold_q;
            green_d       = green_hold_q;
            blue_d        = data_byte_i;
            // not last if a black fill follows
            run_done_d    = !(end_of_frame_i && (pc_inc < Cap));
          end
          default: begin
            byte_phase_d = PhRed;
          end
        endcase
      end

      if (end_of_frame_i) begin
        byte_phase_d = PhRed;
        red_hold_d   = '0;
        green_hold_d = '0;
        if (pixel_count_d < Cap) begin
          fill_d = 1'b1;
        end else begin
          pixel_count_d = '0;
          col_d         = '0;
          row_d         = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_phase_q  <= PhRed;
      red_hold_q    <= '0;
      green_hold_q  <= '0;
      pixel_count_q <= '0;
      col_q         <= '0;
      row_q         <= '0;
      fill_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      byte_phase_q  <= byte_phase_d;
      red_hold_q    <= red_hold_d;
      green_hold_q  <= green_hold_d;
      pixel_count_q <= pixel_count_d;
      col_q         <= col_d;
      row_q         <= row_d;
      fill_q        <= fill_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    strip_q    <= strip_d;
    red_q      <= red_d;
    green_q    <= green_d;
    blue_q     <= blue_d;
    run_done_q <= run_done_d;
  end

  assign out_valid_o   = out_valid_q;
  assign strip_index_o = strip_q;
  assign red_o         = red_q;
  assign green_o       = green_q;
  assign blue_o        = blue_q;
  assign run_done_o    = run_done_q;

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_count_q <= Cap)
    else $error("pixel count beyond capacity");

  a_col_row_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(pixel_count_q) == 32'(row_q) * COLUMNS + 32'(col_q)))
    else $error("col/row out of step with pixel count");

  a_fill_phase_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q |-> (byte_phase_q == PhRed && pixel_count_q < Cap))
    else $error("fill running with bad phase or count");

  a_fill_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q && load_ok && pixel_count_q == CapLast)
      |=> (out_valid_o && run_done_o && !fill_q && pixel_count_q == '0))
    else $error("fill did not close with a final write");
`endif

endmodule
